// ===== src/night_dimming_scheduler_defines.svh =====
// Assertion macros for the night dimming scheduler
`ifndef NIGHT_DIMMING_SCHEDULER_DEFINES_SVH
`define NIGHT_DIMMING_SCHEDULER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define NDS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("nds assertion failed");

// next-cycle implication, disabled during reset
`define NDS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("nds assertion failed");

`endif

// ===== src/nds_pkg.sv =====
// Shared types and constants for the night dimming scheduler
package nds_pkg;

	localparam int CFG_DATA_W = 17;
	localparam int CFG_IDX_W  = 3;
	localparam int IN_TIME_W  = 32;
	localparam int LEVEL_W    = 8;
	localparam logic [16:0] SECS_PER_DAY = 17'd86400;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ENABLED          = 3'd0,
		REG_ON_OFFSET        = 3'd1,
		REG_OFF_OFFSET       = 3'd2,
		REG_SWITCH_INTERVAL  = 3'd3,
		REG_MAX_BRIGHTNESS   = 3'd4,
		REG_NIGHT_BRIGHTNESS = 3'd5,
		REG_DAY_ECO          = 3'd6,
		REG_NIGHT_ECO        = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic        enabled;
		logic [16:0] on_offset;
		logic [16:0] off_offset;
		logic [16:0] switch_interval;
		logic [7:0]  max_brightness;
		logic [7:0]  night_brightness;
		logic [7:0]  day_eco;
		logic [7:0]  night_eco;
	} cfg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EVAL,
		ST_WIN_A,
		ST_WIN_B,
		ST_WIN_C,
		ST_WIN_D,
		ST_FADE,
		ST_DIV,
		ST_MUL,
		ST_BLEND
	} state_t;

	typedef struct packed {
		logic load;
		logic eval;
		logic win_a;
		logic win_b;
		logic win_c;
		logic win_d;
		logic fade;
		logic div_step;
		logic mul;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic act;
		logic flag_new;
		logic win_go;
		logic ramp_go;
		logic div_last;
	} status_t;

endpackage

// ===== src/nds_channels.sv =====
// Valid/ready channel interfaces for tick items and result items
interface nds_in_if;
	import nds_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [IN_TIME_W-1:0] now_time;
	logic [IN_TIME_W-1:0] day_start;
	logic                 time_valid;

	modport source (output valid, now_time, day_start, time_valid, input ready);
	modport sink   (input valid, now_time, day_start, time_valid, output ready);
endinterface

interface nds_out_if #(parameter int FRAC_BITS = 8);
	import nds_pkg::*;
	logic               valid;
	logic               ready;
	logic               active;
	logic               is_night;
	logic [FRAC_BITS:0] fade_level;
	logic [LEVEL_W-1:0] brightness;
	logic [LEVEL_W-1:0] eco_level;

	modport source (output valid, active, is_night, fade_level, brightness, eco_level,
		input ready);
	modport sink   (input valid, active, is_night, fade_level, brightness, eco_level,
		output ready);
endinterface

// ===== src/nds_cfg_regs.sv =====
// Configuration register file with write port
module nds_cfg_regs
	import nds_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enabled          <= 1'b0;
			cfg_q.on_offset        <= '0;
			cfg_q.off_offset       <= '0;
			cfg_q.switch_interval  <= '0;
			cfg_q.max_brightness   <= 8'd255;
			cfg_q.night_brightness <= '0;
			cfg_q.day_eco          <= 8'd255;
			cfg_q.night_eco        <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ENABLED:          cfg_q.enabled          <= cfg_data[0];
				REG_ON_OFFSET:        cfg_q.on_offset        <= cfg_data[16:0];
				REG_OFF_OFFSET:       cfg_q.off_offset       <= cfg_data[16:0];
				REG_SWITCH_INTERVAL:  cfg_q.switch_interval  <= cfg_data[16:0];
				REG_MAX_BRIGHTNESS:   cfg_q.max_brightness   <= cfg_data[7:0];
				REG_NIGHT_BRIGHTNESS: cfg_q.night_brightness <= cfg_data[7:0];
				REG_DAY_ECO:          cfg_q.day_eco          <= cfg_data[7:0];
				REG_NIGHT_ECO:        cfg_q.night_eco        <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== src/nds_ctrl.sv =====
// Sequencer for one tick: evaluate, window update or fade ramp, blend, hand off
module nds_ctrl
	import nds_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q, state_next;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE:  if (in_valid) state_next = ST_EVAL;
			ST_EVAL: begin
				if (!status.act)         state_next = ST_MUL;
				else if (status.flag_new) state_next = ST_FADE;
				else if (status.win_go)   state_next = ST_WIN_A;
				else                      state_next = ST_MUL;
			end
			ST_WIN_A: state_next = ST_WIN_B;
			ST_WIN_B: state_next = ST_WIN_C;
			ST_WIN_C: state_next = ST_WIN_D;
			ST_WIN_D: state_next = ST_MUL;
			ST_FADE:  state_next = status.ramp_go ? ST_DIV : ST_MUL;
			ST_DIV:   if (status.div_last) state_next = ST_MUL;
			ST_MUL:   state_next = ST_BLEND;
			ST_BLEND: if (out_free) state_next = ST_IDLE;
			default:  state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.load     = (state_q == ST_IDLE) && in_valid;
		cmd.eval     = (state_q == ST_EVAL);
		cmd.win_a    = (state_q == ST_WIN_A);
		cmd.win_b    = (state_q == ST_WIN_B);
		cmd.win_c    = (state_q == ST_WIN_C);
		cmd.win_d    = (state_q == ST_WIN_D);
		cmd.fade     = (state_q == ST_FADE);
		cmd.div_step = (state_q == ST_DIV);
		cmd.mul      = (state_q == ST_MUL);
		cmd.out_load = (state_q == ST_BLEND) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.out_load)   out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

// ===== src/nds_dp.sv =====
// Datapath: window registers, window math, fade divider, level blending
module nds_dp
	import nds_pkg::*;
#(
	parameter int TIME_BITS = 32,
	parameter int FRAC_BITS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cfg_t                 cfg,
	input  cmd_t                 cmd,
	output status_t              status,
	input  logic [IN_TIME_W-1:0] now_time,
	input  logic [IN_TIME_W-1:0] day_start,
	input  logic                 time_valid,
	output logic                 active,
	output logic                 is_night,
	output logic [FRAC_BITS:0]   fade_level,
	output logic [LEVEL_W-1:0]   brightness,
	output logic [LEVEL_W-1:0]   eco_level
);

	localparam int CNT_W  = $clog2(FRAC_BITS);
	localparam int PROD_W = LEVEL_W + FRAC_BITS + 1;
	localparam int SUM_W  = LEVEL_W + FRAC_BITS + 2;
	localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};
	localparam logic [TIME_BITS-1:0] DAY = TIME_BITS'(SECS_PER_DAY);

	// tick item
	logic [TIME_BITS-1:0] now_q, day_q;
	logic                 act_q;

	// window state
	logic [TIME_BITS-1:0] fade_in_begin_q, night_begin_q, night_finish_q, fade_out_finish_q;
	logic                 night_flag_q;
	logic [FRAC_BITS:0]   fade_value_q;

	// window scratch
	logic [TIME_BITS-1:0] efade_q, dayw_q;

	// divider
	logic [16:0]          rem_q;
	logic [FRAC_BITS-1:0] quo_q;
	logic [CNT_W-1:0]     cnt_q;

	// blend
	logic [PROD_W-1:0] prod_bri_q, prod_eco_q;
	logic              sub_bri_q, sub_eco_q;

	// result register
	logic               active_q, is_night_q;
	logic [FRAC_BITS:0] fade_level_q;
	logic [7:0]         bri_q, eco_q;

	logic [16:0]          so_sat, eo_sat, sw;
	logic [TIME_BITS-1:0] sw_t, st_val, ramp_dist;
	logic                 in_fade_in, in_full, in_fade_out, use_ramp;
	logic [17:0]          rem_sh, rem_sub;
	logic                 rem_ge;
	logic [FRAC_BITS-1:0] quo_next;
	logic [7:0]           diff_bri, diff_eco;
	logic [SUM_W-1:0]     sum_bri, sum_eco;

	assign sw     = cfg.switch_interval;
	assign sw_t   = TIME_BITS'(sw);
	assign so_sat = (cfg.on_offset > SECS_PER_DAY) ? SECS_PER_DAY : cfg.on_offset;
	assign eo_sat = (cfg.off_offset > SECS_PER_DAY) ? SECS_PER_DAY : cfg.off_offset;

	// night start; an offset past the end one belongs to the previous day
	assign st_val = dayw_q + TIME_BITS'(so_sat)
		- ((so_sat > eo_sat) ? DAY : '0);

	always_comb begin
		in_fade_in  = now_q < night_begin_q;
		in_full     = !in_fade_in && (now_q < night_finish_q);
		in_fade_out = !in_fade_in && !in_full && (now_q < fade_out_finish_q);
		use_ramp    = in_fade_in || in_fade_out;
		ramp_dist   = in_fade_in ? (night_begin_q - now_q) : (fade_out_finish_q - now_q);
	end

	// restoring division, one quotient bit per cycle
	assign rem_sh   = {rem_q, 1'b0};
	assign rem_ge   = rem_sh >= {1'b0, sw};
	assign rem_sub  = rem_sh - {1'b0, sw};
	assign quo_next = {quo_q[FRAC_BITS-2:0], rem_ge};

	always_comb begin
		status.act      = act_q;
		status.flag_new = (now_q >= fade_in_begin_q) && (now_q <= fade_out_finish_q);
		status.win_go   = !status.flag_new && (now_q > fade_in_begin_q);
		status.ramp_go  = use_ramp && (sw != '0) && (ramp_dist < sw_t);
		status.div_last = (cnt_q == CNT_W'(FRAC_BITS - 1));
	end

	assign diff_bri = (cfg.max_brightness >= cfg.night_brightness)
		? cfg.max_brightness - cfg.night_brightness
		: cfg.night_brightness - cfg.max_brightness;
	assign diff_eco = (cfg.day_eco >= cfg.night_eco)
		? cfg.day_eco - cfg.night_eco
		: cfg.night_eco - cfg.day_eco;

	assign sum_bri = sub_bri_q
		? (SUM_W'(cfg.max_brightness) << FRAC_BITS) - SUM_W'(prod_bri_q)
		: (SUM_W'(cfg.max_brightness) << FRAC_BITS) + SUM_W'(prod_bri_q);
	assign sum_eco = sub_eco_q
		? (SUM_W'(cfg.day_eco) << FRAC_BITS) - SUM_W'(prod_eco_q)
		: (SUM_W'(cfg.day_eco) << FRAC_BITS) + SUM_W'(prod_eco_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fade_in_begin_q   <= '0;
			night_begin_q     <= '0;
			night_finish_q    <= '0;
			fade_out_finish_q <= '0;
			night_flag_q      <= 1'b0;
			fade_value_q      <= '0;
		end else begin
			if (cmd.eval && act_q) night_flag_q <= status.flag_new;
			if (cmd.win_c) begin
				night_begin_q     <= st_val;
				night_finish_q    <= efade_q - sw_t;
				fade_out_finish_q <= efade_q;
			end
			if (cmd.win_d) fade_in_begin_q <= night_begin_q - sw_t;
			if (cmd.fade && !status.ramp_go) fade_value_q <= in_full ? ONE : '0;
			if (cmd.div_step && status.div_last) fade_value_q <= {1'b0, quo_next};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			now_q <= TIME_BITS'(now_time);
			day_q <= TIME_BITS'(day_start);
			act_q <= cfg.enabled && time_valid;
		end
		if (cmd.win_a) begin
			efade_q <= day_q + TIME_BITS'(eo_sat) + sw_t;
			dayw_q  <= day_q;
		end
		// past tonight's end: move the window to the next day
		if (cmd.win_b && (now_q > efade_q)) begin
			efade_q <= efade_q + DAY;
			dayw_q  <= dayw_q + DAY;
		end
		if (cmd.fade) begin
			rem_q <= sw - ramp_dist[16:0];
			quo_q <= '0;
			cnt_q <= '0;
		end
		if (cmd.div_step) begin
			rem_q <= rem_ge ? rem_sub[16:0] : rem_sh[16:0];
			quo_q <= quo_next;
			cnt_q <= cnt_q + CNT_W'(1);
		end
		if (cmd.mul) begin
			prod_bri_q <= PROD_W'(diff_bri) * PROD_W'(fade_value_q);
			prod_eco_q <= PROD_W'(diff_eco) * PROD_W'(fade_value_q);
			sub_bri_q  <= cfg.max_brightness >= cfg.night_brightness;
			sub_eco_q  <= cfg.day_eco >= cfg.night_eco;
		end
		if (cmd.out_load) begin
			active_q     <= act_q;
			is_night_q   <= night_flag_q;
			fade_level_q <= fade_value_q;
			bri_q        <= sum_bri[FRAC_BITS+7:FRAC_BITS];
			eco_q        <= sum_eco[FRAC_BITS+7:FRAC_BITS];
		end
	end

	assign active     = active_q;
	assign is_night   = is_night_q;
	assign fade_level = fade_level_q;
	assign brightness = bri_q;
	assign eco_level  = eco_q;

endmodule

// ===== src/night_dimming_scheduler.sv =====
// An item runs evaluate, multiply and blend; a window update adds the window steps
// A to D, and a fade ramp adds the fade step and the one-bit-per-cycle fade divider.
// The blend waits until the output register is free. One item in flight; the next
// is accepted the cycle after the result is loaded into the output register.
// Reset (arst_n low, asynchronous): window times, night flag and fade clear to 0,
// registers take their defaults, no result pending.
`include "night_dimming_scheduler_defines.svh"

module night_dimming_scheduler
	import nds_pkg::*;
#(
	parameter int TIME_BITS     = 32,
	parameter int FRACTION_BITS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	nds_in_if.sink                in_ch,
	nds_out_if.source             out_ch,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t    cfg;
	cmd_t    cmd;
	status_t status;

	nds_cfg_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	nds_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.status    (status),
		.cmd       (cmd)
	);

	nds_dp #(
		.TIME_BITS (TIME_BITS),
		.FRAC_BITS (FRACTION_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.cmd        (cmd),
		.status     (status),
		.now_time   (in_ch.now_time),
		.day_start  (in_ch.day_start),
		.time_valid (in_ch.time_valid),
		.active     (out_ch.active),
		.is_night   (out_ch.is_night),
		.fade_level (out_ch.fade_level),
		.brightness (out_ch.brightness),
		.eco_level  (out_ch.eco_level)
	);

	`NDS_ASSERT_NEXT(a_one_in_flight, clk, arst_n, in_ch.valid && in_ch.ready, !in_ch.ready)
	`NDS_ASSERT_NOW(a_cmd_onehot, clk, arst_n, 1'b1, $onehot0(cmd))
	`NDS_ASSERT_NOW(a_fade_max, clk, arst_n, out_ch.valid && out_ch.fade_level[FRACTION_BITS],
		out_ch.fade_level[FRACTION_BITS-1:0] == '0)

endmodule
